@@ src/rv64ls_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rv64ls_pkg
// Types, codes and field positions of the RV64 load/store emulation unit.
// ----------------------------------------------------------------------------
package rv64ls_pkg;

    localparam int unsigned XLEN     = 64;
    localparam int unsigned NREG     = 32;
    localparam int unsigned RIDX_W   = 5;
    localparam int unsigned INSN_W   = 32;
    localparam int unsigned SETIDX_W = 6;
    localparam logic [SETIDX_W-1:0] PC_INDEX = 6'd32;

    // input tdata layout, lowest bit up
    localparam int unsigned IN_INSN_LO  = 0;
    localparam int unsigned IN_ADDR_LO  = IN_INSN_LO + INSN_W;
    localparam int unsigned IN_LDATA_LO = IN_ADDR_LO + XLEN;
    localparam int unsigned IN_RIDX_LO  = IN_LDATA_LO + XLEN;
    localparam int unsigned IN_RVAL_LO  = IN_RIDX_LO + SETIDX_W;
    localparam int unsigned IN_USED_W   = IN_RVAL_LO + XLEN;
    localparam int unsigned IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int unsigned IN_TUSER_W  = 2;

    // output tdata layout, lowest bit up
    localparam int unsigned OUT_USED_W  = 2 + 2 + XLEN + XLEN + RIDX_W + XLEN + XLEN;
    localparam int unsigned OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int unsigned OUT_TUSER_W = 2;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_STORE = 2'd1,
        OP_SET   = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FUNCT = 2'd1,
        ST_QUAD  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    localparam logic [1:0] Q_C0  = 2'b00;
    localparam logic [1:0] Q_C1  = 2'b01;
    localparam logic [1:0] Q_C2  = 2'b10;
    localparam logic [1:0] Q_STD = 2'b11;

    localparam logic [2:0] F3_CLW = 3'b010;
    localparam logic [2:0] F3_CLD = 3'b011;
    localparam logic [2:0] F3_CSW = 3'b110;
    localparam logic [2:0] F3_CSD = 3'b111;
    localparam logic [2:0] F3_BAD = 3'b111;

    localparam logic [XLEN-1:0] STEP_STD = XLEN'(4);
    localparam logic [XLEN-1:0] STEP_C   = XLEN'(2);

    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic [XLEN-1:0]   dest_value;
        logic [RIDX_W-1:0] dest_index;
        logic              dest_valid;
        logic [XLEN-1:0]   write_data;
        logic [XLEN-1:0]   mem_address;
        logic [1:0]        access_size;
        logic              mem_write;
        t_status           status;
    } t_result;

    function automatic logic [XLEN-1:0] size_mask(input logic [1:0] size);
        logic [XLEN-1:0] m;
        case (size)
            2'd0:    m = XLEN'(8'hFF);
            2'd1:    m = XLEN'(16'hFFFF);
            2'd2:    m = XLEN'(32'hFFFF_FFFF);
            default: m = '1;
        endcase
        return m;
    endfunction

    function automatic logic [XLEN-1:0] extend_data(input logic [XLEN-1:0] data,
                                                    input logic [1:0]      size,
                                                    input logic            sgn);
        logic [XLEN-1:0] v;
        case (size)
            2'd0:    v = {{(XLEN-8){sgn & data[7]}}, data[7:0]};
            2'd1:    v = {{(XLEN-16){sgn & data[15]}}, data[15:0]};
            2'd2:    v = {{(XLEN-32){sgn & data[31]}}, data[31:0]};
            default: v = data;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ src/rv64_load_store_emulator_unit.sv @@
// Input transfers land in the input register, results in the result register.
// Throughput: one item per cycle; input register, decode/execute logic and
// result register advance together whenever the result register is free or taken.
// Register file and program counter live in flip-flops and update as an item executes.
// Reset clears all registers, the program counter and both stage valids.
`default_nettype none
// ----------------------------------------------------------------------------
// rv64_load_store_emulator_unit
// Executes trapped RV64 loads, stores and frame writes against a kept trap frame.
// ----------------------------------------------------------------------------
module rv64_load_store_emulator_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // instruction, access_address, load_data, reg_index, reg_value, zero pad
    input  wire logic [rv64ls_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // operation
    input  wire logic [rv64ls_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // status, access_size, mem_address, write_data, dest_index, dest_value,
    // next_pc, zero pad
    output logic [rv64ls_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    // mem_write, dest_valid
    output logic [rv64ls_pkg::OUT_TUSER_W-1:0]      o_m_tuser
);
    import rv64ls_pkg::*;

    logic                  r_in_v;
    logic [IN_TDATA_W-1:0] r_tdata;
    t_op                   r_op;
    logic                  r_out_v;
    logic                  r_out_new;
    t_result               r_out;
    logic [XLEN-1:0]       r_regs [NREG];
    logic [XLEN-1:0]       r_pc;

    logic                  advance;
    logic                  exec;
    t_result               n_out;
    logic [XLEN-1:0]       n_pc;
    logic                  wr_en;
    logic [RIDX_W-1:0]     wr_idx;

    logic [INSN_W-1:0]     ins;
    logic [XLEN-1:0]       addr;
    logic [XLEN-1:0]       ldata;
    logic [SETIDX_W-1:0]   ridx;
    logic [XLEN-1:0]       rval;
    logic [1:0]            quad;
    logic [2:0]            f3;

    assign ins   = r_tdata[IN_INSN_LO  +: INSN_W];
    assign addr  = r_tdata[IN_ADDR_LO  +: XLEN];
    assign ldata = r_tdata[IN_LDATA_LO +: XLEN];
    assign ridx  = r_tdata[IN_RIDX_LO  +: SETIDX_W];
    assign rval  = r_tdata[IN_RVAL_LO  +: XLEN];
    assign quad  = ins[1:0];
    assign f3    = ins[14:12];

    assign advance    = !r_out_v || i_m_tready;
    assign exec       = r_in_v && advance;
    assign o_s_tready = !r_in_v || advance;

    always_comb begin
        logic              ok;
        logic              sgn;
        logic [1:0]        size;
        logic [RIDX_W-1:0] rsel;
        logic [XLEN-1:0]   step;
        logic [XLEN-1:0]   val;

        n_out  = '0;
        n_out.status = ST_OK;
        n_pc   = r_pc;
        wr_en  = 1'b0;
        wr_idx = '0;
        ok     = 1'b0;
        sgn    = 1'b0;
        size   = '0;
        rsel   = '0;
        step   = (quad == Q_STD) ? STEP_STD : STEP_C;
        val    = '0;

        case (r_op)
            OP_SET: begin
                if (ridx == PC_INDEX) begin
                    n_pc = rval;
                end else if (ridx < SETIDX_W'(NREG) && ridx != '0) begin
                    wr_en = 1'b1;
                    wr_idx = ridx[RIDX_W-1:0];
                    n_out.dest_valid = 1'b1;
                    n_out.dest_index = ridx[RIDX_W-1:0];
                    n_out.dest_value = rval;
                end
            end
            OP_LOAD: begin
                if (quad == Q_C1) begin
                    n_out.status = ST_QUAD;
                end else begin
                    if (quad == Q_STD) begin
                        rsel = ins[11:7];
                        ok   = (f3 != F3_BAD);
                        size = f3[1:0];
                        sgn  = !f3[2];
                    end else begin
                        rsel = (quad == Q_C2) ? ins[11:7] : {2'b01, ins[4:2]};
                        ok   = f3 inside {F3_CLW, F3_CLD};
                        size = f3[1:0];
                        sgn  = 1'b1;
                    end
                    val = ok ? extend_data(ldata, size, sgn) : '0;
                    if (rsel != '0) begin
                        wr_en = 1'b1;
                        wr_idx = rsel;
                        n_out.dest_valid = 1'b1;
                        n_out.dest_index = rsel;
                        n_out.dest_value = val;
                    end
                    if (ok) begin
                        n_out.access_size = size;
                    end else begin
                        n_out.status = ST_FUNCT;
                    end
                    n_pc = r_pc + step;
                end
            end
            OP_STORE: begin
                if (quad == Q_C1) begin
                    n_out.status = ST_QUAD;
                end else begin
                    if (quad == Q_STD) begin
                        rsel = ins[24:20];
                        ok   = !f3[2];
                    end else begin
                        rsel = (quad == Q_C2) ? ins[6:2] : {2'b01, ins[4:2]};
                        ok   = f3 inside {F3_CSW, F3_CSD};
                    end
                    size = f3[1:0];
                    if (ok) begin
                        n_out.mem_write   = 1'b1;
                        n_out.access_size = size;
                        n_out.mem_address = addr;
                        n_out.write_data  = r_regs[rsel] & size_mask(size);
                    end else begin
                        n_out.status = ST_FUNCT;
                    end
                    n_pc = r_pc + step;
                end
            end
            default: begin
            end
        endcase
        n_out.next_pc = n_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v    <= 1'b0;
            r_out_v   <= 1'b0;
            r_out_new <= 1'b0;
            r_pc      <= '0;
            for (int i = 0; i < NREG; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (o_s_tready) begin
                r_in_v <= i_s_tvalid;
            end
            if (advance) begin
                r_out_v <= r_in_v;
            end
            r_out_new <= exec;
            if (exec) begin
                r_pc <= n_pc;
                if (wr_en) begin
                    r_regs[wr_idx] <= n_out.dest_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_tdata <= i_s_tdata;
            r_op    <= t_op'(i_s_tuser);
        end
        if (exec) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = {r_out.dest_valid, r_out.mem_write};
    assign o_m_tdata  = OUT_TDATA_W'({r_out.next_pc, r_out.dest_value, r_out.dest_index,
                                      r_out.write_data, r_out.mem_address,
                                      r_out.access_size, r_out.status});

    a_zero_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs[0] == '0)
        else $error("register zero was written");

    a_dest_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.dest_valid |-> r_out.dest_index != '0)
        else $error("result reports a write to register zero");

    a_quad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.status == ST_QUAD |-> !r_out.mem_write && !r_out.dest_valid)
        else $error("unsupported quadrant caused an effect");

    a_store_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.mem_write |-> r_out.status == ST_OK)
        else $error("store access issued with an error status");

    a_pc_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_new |-> r_pc == r_out.next_pc)
        else $error("program counter differs from reported next_pc");

    a_reg_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_new && r_out.dest_valid |-> r_regs[r_out.dest_index] == r_out.dest_value)
        else $error("register file differs from reported write");

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives trapped loads, stores and trap-frame writes into the load/store
// emulation unit through its stream ports, with random gaps on both sides.
// It keeps its own copy of the register file and program counter, works out
// the expected result of each input transfer and compares every output
// transfer field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import rv64ls_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RAND_PER_PHASE = 170;

    // standard funct3 codes
    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LD  = 3'd3;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;
    localparam logic [2:0] F3_LWU = 3'd6;
    localparam logic [2:0] F3_SB  = 3'd0;
    localparam logic [2:0] F3_SH  = 3'd1;
    localparam logic [2:0] F3_SW  = 3'd2;
    localparam logic [2:0] F3_SD  = 3'd3;
    localparam logic [2:0] F3_S4  = 3'd4;

    // output tdata layout
    localparam int unsigned O_STATUS = 0;
    localparam int unsigned O_SIZE   = 2;
    localparam int unsigned O_MADDR  = 4;
    localparam int unsigned O_WDATA  = O_MADDR + XLEN;
    localparam int unsigned O_DIDX   = O_WDATA + XLEN;
    localparam int unsigned O_DVAL   = O_DIDX + RIDX_W;
    localparam int unsigned O_NPC    = O_DVAL + XLEN;

    typedef struct packed {
        t_op                 op;
        logic [INSN_W-1:0]   insn;
        logic [XLEN-1:0]     addr;
        logic [XLEN-1:0]     ldata;
        logic [SETIDX_W-1:0] ridx;
        logic [XLEN-1:0]     rval;
    } trap_item_t;

    typedef struct packed {
        t_status           status;
        logic              mem_write;
        logic [1:0]        size;
        logic [XLEN-1:0]   maddr;
        logic [XLEN-1:0]   wdata;
        logic              dvalid;
        logic [RIDX_W-1:0] didx;
        logic [XLEN-1:0]   dval;
        logic [XLEN-1:0]   npc;
    } trap_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic [IN_TUSER_W-1:0]  s_user = '0;
    logic                   o_m_tvalid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;

    trap_item_t   pending_q[$];
    trap_result_t result_q[$];
    trap_item_t   drive_item;
    trap_result_t seen_res;
    trap_result_t want_res;

    logic [XLEN-1:0] frame_regs[NREG];
    logic [XLEN-1:0] frame_pc;

    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned fail_cnt = 0;
    int unsigned quiet_cycles = 0;

    rv64_load_store_emulator_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [XLEN-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [XLEN-1:0] lane_mask(input logic [1:0] size);
        logic [XLEN-1:0] m;
        m = '1;
        if (size != 2'd3) begin
            m = (XLEN'(1) << (8 << size)) - XLEN'(1);
        end
        return m;
    endfunction

    function automatic logic [INSN_W-1:0] make_word(input logic [1:0] quad,
                                                    input logic [2:0] f3,
                                                    input logic [4:0] rd,
                                                    input logic [4:0] rs2,
                                                    input logic [4:0] lo);
        return {7'd0, rs2, 5'd0, f3, rd, lo[4:0] & 5'h1F, 2'b00} | INSN_W'(quad);
    endfunction

    function automatic trap_item_t make_item(input t_op op, input logic [INSN_W-1:0] insn,
                                             input logic [XLEN-1:0] ldata,
                                             input logic [SETIDX_W-1:0] ridx,
                                             input logic [XLEN-1:0] rval);
        trap_item_t it;
        it.op    = op;
        it.insn  = insn;
        it.addr  = rand64();
        it.ldata = ldata;
        it.ridx  = ridx;
        it.rval  = rval;
        return it;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_item(input trap_item_t it);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[IN_INSN_LO +: INSN_W]    = it.insn;
        d[IN_ADDR_LO +: XLEN]      = it.addr;
        d[IN_LDATA_LO +: XLEN]     = it.ldata;
        d[IN_RIDX_LO +: SETIDX_W]  = it.ridx;
        d[IN_RVAL_LO +: XLEN]      = it.rval;
        return d;
    endfunction

    // Execute one item against the kept trap frame.
    function automatic trap_result_t execute_trap(input trap_item_t it);
        trap_result_t    r;
        logic [1:0]      quad;
        logic [2:0]      f3;
        logic [4:0]      rsel;
        logic [1:0]      size;
        logic            ok;
        logic            sgn;
        logic [XLEN-1:0] m;
        logic [XLEN-1:0] v;
        r = '0;
        r.status = ST_OK;
        quad = it.insn[1:0];
        f3 = it.insn[14:12];
        ok = 1'b0;
        sgn = 1'b0;
        size = f3[1:0];
        if (it.op == OP_SET) begin
            if (it.ridx == PC_INDEX) begin
                frame_pc = it.rval;
            end else if (it.ridx > 0 && it.ridx < NREG) begin
                frame_regs[it.ridx[4:0]] = it.rval;
                r.dvalid = 1'b1;
                r.didx = it.ridx[4:0];
                r.dval = it.rval;
            end
        end else if (it.op != OP_NONE && quad == Q_C1) begin
            r.status = ST_QUAD;
        end else if (it.op != OP_NONE) begin
            if (it.op == OP_LOAD) begin
                if (quad == Q_STD) begin
                    rsel = it.insn[11:7];
                    ok = (f3 != F3_BAD);
                    sgn = !f3[2];
                end else begin
                    rsel = (quad == Q_C2) ? it.insn[11:7] : {2'b01, it.insn[4:2]};
                    ok = (f3 == F3_CLW || f3 == F3_CLD);
                    sgn = 1'b1;
                end
                v = '0;
                if (ok) begin
                    m = lane_mask(size);
                    v = it.ldata & m;
                    if (sgn && size != 2'd3 && v[(8 << size) - 1]) begin
                        v = v | ~m;
                    end
                    r.size = size;
                end
                if (rsel != 5'd0) begin
                    frame_regs[rsel] = v;
                    r.dvalid = 1'b1;
                    r.didx = rsel;
                    r.dval = v;
                end
            end else begin
                if (quad == Q_STD) begin
                    rsel = it.insn[24:20];
                    ok = (f3 <= F3_SD);
                end else begin
                    rsel = (quad == Q_C2) ? it.insn[6:2] : {2'b01, it.insn[4:2]};
                    ok = (f3 == F3_CSW || f3 == F3_CSD);
                end
                if (ok) begin
                    r.mem_write = 1'b1;
                    r.size = size;
                    r.maddr = it.addr;
                    r.wdata = frame_regs[rsel] & lane_mask(size);
                end
            end
            if (!ok) begin
                r.status = ST_FUNCT;
            end
            frame_pc = frame_pc + ((quad == Q_STD) ? STEP_STD : STEP_C);
        end
        r.npc = frame_pc;
        return r;
    endfunction

    function automatic trap_item_t rand_item();
        trap_item_t it;
        int unsigned pick;
        logic [1:0]  quad;
        logic [2:0]  f3;
        it = make_item(OP_NONE, $urandom(), rand64(), 6'($urandom()), rand64());
        pick = $urandom_range(99);
        if (pick < 15) begin
            it.op = OP_SET;
            pick = $urandom_range(99);
            if (pick < 85) begin
                it.ridx = 6'($urandom_range(NREG - 1));
            end else if (pick < 95) begin
                it.ridx = PC_INDEX;
            end else begin
                it.ridx = 6'($urandom_range(63, 33));
            end
        end else if (pick < 95) begin
            it.op = (pick < 55) ? OP_LOAD : OP_STORE;
            pick = $urandom_range(9);
            quad = (pick == 0) ? Q_C1 : (pick < 4) ? Q_C0 : (pick < 7) ? Q_C2 : Q_STD;
            f3 = 3'($urandom());
            if ($urandom_range(99) < 85) begin
                if (quad == Q_STD) begin
                    f3 = (it.op == OP_LOAD) ? 3'($urandom_range(6)) : 3'($urandom_range(3));
                end else if (it.op == OP_LOAD) begin
                    f3 = $urandom_range(1) ? F3_CLD : F3_CLW;
                end else begin
                    f3 = $urandom_range(1) ? F3_CSD : F3_CSW;
                end
            end
            it.insn[1:0] = quad;
            it.insn[14:12] = f3;
        end
        return it;
    endfunction

    task automatic check_field(input string name, input logic [XLEN-1:0] want,
                               input logic [XLEN-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_cnt++;
        end
    endtask

    task automatic load_directed();
        pending_q.push_back(make_item(OP_STORE, make_word(Q_STD, F3_SD, 0, 5, 0), 0, 0, 0));
        pending_q.push_back(make_item(OP_SET, 0, 0, 6'd1, '1));
        pending_q.push_back(make_item(OP_SET, 0, 0, 6'd31, 64'h8000_0000_0000_0001));
        pending_q.push_back(make_item(OP_SET, 0, 0, 6'd15, 64'h0123_4567_89AB_CDEF));
        pending_q.push_back(make_item(OP_SET, 0, 0, 6'd0, rand64()));
        pending_q.push_back(make_item(OP_SET, 0, 0, 6'd63, rand64()));
        pending_q.push_back(make_item(OP_SET, 0, 0, PC_INDEX, 64'hFFFF_FFFF_FFFF_FFFC));
        pending_q.push_back(make_item(OP_NONE, $urandom(), rand64(), 6'd1, rand64()));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_STD, F3_LB, 2, 0, 0), 64'h80, 0, 0));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_STD, F3_LBU, 3, 0, 0), '1, 0, 0));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_STD, F3_LH, 4, 0, 0), 64'h8000, 0, 0));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_STD, F3_LHU, 5, 0, 0), '1, 0, 0));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_STD, F3_LW, 6, 0, 0),
                                      64'h1234_5678_8000_0000, 0, 0));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_STD, F3_LWU, 7, 0, 0), '1, 0, 0));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_STD, F3_LD, 9, 0, 0), '1, 0, 0));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_STD, F3_BAD, 6, 0, 0), '1, 0, 0));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_STD, F3_LW, 0, 0, 0), '1, 0, 0));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_C2, F3_CLW, 10, 0, 0),
                                      64'hFFFF_FFFF_7FFF_FFFF, 0, 0));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_C2, F3_CLD, 11, 0, 0), '1, 0, 0));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_C0, F3_CLW, 0, 0, 5'd7), '1, 0, 0));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_C0, F3_LB, 0, 0, 5'd0), '1, 0, 0));
        pending_q.push_back(make_item(OP_STORE, make_word(Q_STD, F3_SB, 0, 1, 0), 0, 0, 0));
        pending_q.push_back(make_item(OP_STORE, make_word(Q_STD, F3_SH, 0, 31, 0), 0, 0, 0));
        pending_q.push_back(make_item(OP_STORE, make_word(Q_STD, F3_SW, 0, 31, 0), 0, 0, 0));
        pending_q.push_back(make_item(OP_STORE, make_word(Q_STD, F3_S4, 0, 1, 0), 0, 0, 0));
        pending_q.push_back(make_item(OP_STORE, make_word(Q_C2, F3_CSW, 0, 0, 31), 0, 0, 0));
        pending_q.push_back(make_item(OP_STORE, make_word(Q_C2, F3_CSD, 0, 0, 0), 0, 0, 0));
        pending_q.push_back(make_item(OP_STORE, make_word(Q_C0, F3_CSD, 0, 0, 5'd7), 0, 0, 0));
        pending_q.push_back(make_item(OP_STORE, make_word(Q_C0, F3_CLW, 0, 0, 5'd7), 0, 0, 0));
        pending_q.push_back(make_item(OP_LOAD, make_word(Q_C1, F3_CLW, 12, 0, 0), '1, 0, 0));
        pending_q.push_back(make_item(OP_STORE, make_word(Q_C1, F3_CSD, 0, 0, 1), 0, 0, 0));
    endtask

    // input side: advance to the next pending item once the current transfer completes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_tready) begin
                result_q.push_back(execute_trap(drive_item));
            end
            if (!s_valid || o_s_tready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    drive_item = pending_q.pop_front();
                    s_valid <= 1'b1;
                    s_data <= pack_item(drive_item);
                    s_user <= drive_item.op;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // output side: compare each transfer with the oldest expected result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_cnt++;
                end else begin
                    want_res = result_q.pop_front();
                    seen_res.status    = t_status'(o_m_tdata[O_STATUS +: 2]);
                    seen_res.mem_write = o_m_tuser[0];
                    seen_res.size      = o_m_tdata[O_SIZE +: 2];
                    seen_res.maddr     = o_m_tdata[O_MADDR +: XLEN];
                    seen_res.wdata     = o_m_tdata[O_WDATA +: XLEN];
                    seen_res.dvalid    = o_m_tuser[1];
                    seen_res.didx      = o_m_tdata[O_DIDX +: RIDX_W];
                    seen_res.dval      = o_m_tdata[O_DVAL +: XLEN];
                    seen_res.npc       = o_m_tdata[O_NPC +: XLEN];
                    check_field("status", XLEN'(want_res.status), XLEN'(seen_res.status));
                    check_field("mem_write", XLEN'(want_res.mem_write),
                                XLEN'(seen_res.mem_write));
                    check_field("access_size", XLEN'(want_res.size), XLEN'(seen_res.size));
                    check_field("mem_address", want_res.maddr, seen_res.maddr);
                    check_field("write_data", want_res.wdata, seen_res.wdata);
                    check_field("dest_valid", XLEN'(want_res.dvalid), XLEN'(seen_res.dvalid));
                    check_field("dest_index", XLEN'(want_res.didx), XLEN'(seen_res.didx));
                    check_field("dest_value", want_res.dval, seen_res.dval);
                    check_field("next_pc", want_res.npc, seen_res.npc);
                end
            end
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && o_s_tready) || (o_m_tvalid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < NREG; i++) begin
            frame_regs[i] = '0;
        end
        frame_pc = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            @(negedge i_clk);
            snd_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 51 : 0;
            rcv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 27 : 0;
            if (phase == 0) begin
                load_directed();
            end
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                pending_q.push_back(rand_item());
            end
            while (pending_q.size() != 0 || s_valid) @(posedge i_clk);
        end
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/rv64ls_pkg.sv
src/rv64_load_store_emulator_unit.sv
bench/testbench.sv
